/* src/icf_pkg.sv */
// ----------------------------------------------------------------------------
// icf_pkg
// shared types, format codes and the digit glyph function for the formatter
// ----------------------------------------------------------------------------
package icf_pkg;

    // default operand width
    localparam int ICF_VALUE_BITS = 32;

    // format selector codes
    localparam logic [1:0] OP_UDEC = 2'd0;
    localparam logic [1:0] OP_SDEC = 2'd1;
    localparam logic [1:0] OP_OCT  = 2'd2;
    localparam logic [1:0] OP_HEX  = 2'd3;

    // ascii codes
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_ALPHA = 8'h37;   // 'A' - 10
    localparam logic [7:0] CH_X     = 8'h78;
    localparam logic [7:0] CH_MINUS = 8'h2D;

    // text put in front of the digits
    typedef enum logic [1:0] {
        PFX_NONE,
        PFX_MINUS,
        PFX_HEX
    } t_prefix;

    // load command from the control to the emitter
    typedef struct packed {
        logic    load;
        t_prefix prefix;
    } t_emit_cmd;

    // control sequencer states
    typedef enum logic [1:0] {
        T_IDLE,
        T_CONV,
        T_EMIT
    } t_top_state;

    // emitter states
    typedef enum logic [2:0] {
        E_IDLE,
        E_SKIP,
        E_PRE,
        E_PRE2,
        E_DIG
    } t_emit_state;

    // digit value to upper-case ascii glyph
    function automatic logic [7:0] glyph(input logic [3:0] d);
        glyph = (d < 4'd10) ? (CH_ZERO + {4'b0000, d}) : (CH_ALPHA + {4'b0000, d});
    endfunction

endpackage

/* src/icf_dabble.sv */
// ----------------------------------------------------------------------------
// icf_dabble
// bit-serial binary to bcd converter, shift-and-add-3, one bit per cycle
// ----------------------------------------------------------------------------
module icf_dabble #(
    parameter int VALUE_BITS = 32,
    parameter int DEC_DIGITS = 10
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_start,
    input  logic [VALUE_BITS-1:0]     i_value,
    output logic                      o_done,
    output logic [4*DEC_DIGITS-1:0]   o_bcd
);
    import icf_pkg::*;

    localparam int CW = $clog2(VALUE_BITS + 1);

    logic [VALUE_BITS-1:0]   r_shift;
    logic [4*DEC_DIGITS-1:0] r_bcd;
    logic [4*DEC_DIGITS-1:0] n_adj;
    logic [CW-1:0]           r_cnt;
    logic                    r_busy;
    logic                    r_done;

    // add 3 to every digit of 5 or more before the shift
    always_comb begin
        for (int i = 0; i < DEC_DIGITS; i++) begin
            if (r_bcd[4*i +: 4] >= 4'd5) begin
                n_adj[4*i +: 4] = r_bcd[4*i +: 4] + 4'd3;
            end else begin
                n_adj[4*i +: 4] = r_bcd[4*i +: 4];
            end
        end
    end

    // control: bit counter and done pulse
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CW'(VALUE_BITS);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // datapath: shift one bit of the binary into the bcd register
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_shift <= i_value;
            r_bcd   <= '0;
        end else if (r_busy) begin
            r_shift <= {r_shift[VALUE_BITS-2:0], 1'b0};
            r_bcd   <= {n_adj[4*DEC_DIGITS-2:0], r_shift[VALUE_BITS-1]};
        end
    end

    assign o_done = r_done;
    assign o_bcd  = r_bcd;

endmodule

/* src/icf_emit.sv */
// ----------------------------------------------------------------------------
// icf_emit
// character emitter: drops leading zeros, sends prefix and digits, one per beat
// ----------------------------------------------------------------------------
module icf_emit #(
    parameter int NDIG = 11
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  icf_pkg::t_emit_cmd       i_cmd,
    input  logic [4*NDIG-1:0]        i_digits,
    output logic                     o_idle,
    output logic                     o_m_tvalid,
    input  logic                     i_m_tready,
    output logic [7:0]               o_m_tdata,
    output logic                     o_m_tlast
);
    import icf_pkg::*;

    localparam int CW = $clog2(NDIG + 1);

    t_emit_state         r_state, n_state;
    t_prefix             r_prefix;
    logic [4*NDIG-1:0]   r_dig;
    logic [CW-1:0]       r_cnt;
    logic                r_ovalid;
    logic [7:0]          r_ochar;
    logic                r_olast;

    logic                out_free;
    logic [3:0]          top_dig;
    logic                shift_en;
    logic                put_en;
    logic [7:0]          put_char;
    logic                put_last;

    assign out_free = !r_ovalid || i_m_tready;
    assign top_dig  = r_dig[4*NDIG-1 -: 4];

    // next state and beat generation
    always_comb begin
        n_state  = r_state;
        shift_en = 1'b0;
        put_en   = 1'b0;
        put_char = CH_ZERO;
        put_last = 1'b0;
        unique case (r_state)
            E_IDLE: begin
                if (i_cmd.load) begin
                    n_state = E_SKIP;
                end
            end
            E_SKIP: begin
                if (r_cnt > CW'(1) && top_dig == 4'd0) begin
                    shift_en = 1'b1;
                end else if (r_prefix == PFX_NONE) begin
                    n_state = E_DIG;
                end else begin
                    n_state = E_PRE;
                end
            end
            E_PRE: begin
                if (out_free) begin
                    put_en   = 1'b1;
                    put_char = (r_prefix == PFX_MINUS) ? CH_MINUS : CH_ZERO;
                    n_state  = (r_prefix == PFX_HEX) ? E_PRE2 : E_DIG;
                end
            end
            E_PRE2: begin
                if (out_free) begin
                    put_en   = 1'b1;
                    put_char = CH_X;
                    n_state  = E_DIG;
                end
            end
            E_DIG: begin
                if (out_free) begin
                    put_en   = 1'b1;
                    put_char = glyph(top_dig);
                    put_last = (r_cnt == CW'(1));
                    shift_en = 1'b1;
                    if (r_cnt == CW'(1)) begin
                        n_state = E_IDLE;
                    end
                end
            end
            default: n_state = E_IDLE;
        endcase
    end

    // state and output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= E_IDLE;
            r_ovalid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (put_en) begin
                r_ovalid <= 1'b1;
            end else if (i_m_tready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    // digit shift register, digit count and output beat
    always_ff @(posedge i_clk) begin
        if (r_state == E_IDLE && i_cmd.load) begin
            r_dig    <= i_digits;
            r_cnt    <= CW'(NDIG);
            r_prefix <= i_cmd.prefix;
        end else if (shift_en) begin
            r_dig <= {r_dig[4*NDIG-5:0], 4'd0};
            r_cnt <= r_cnt - 1'b1;
        end
        if (put_en) begin
            r_ochar <= put_char;
            r_olast <= put_last;
        end
    end

    assign o_idle     = (r_state == E_IDLE);
    assign o_m_tvalid = r_ovalid;
    assign o_m_tdata  = r_ochar;
    assign o_m_tlast  = r_olast;

endmodule

/* src/integer_to_ascii_formatter_unit.sv */
// ----------------------------------------------------------------------------
// integer_to_ascii_formatter_unit
// integer to ascii text in unsigned/signed decimal, octal or 0x hexadecimal
// ----------------------------------------------------------------------------
// usage
//   slave channel: one beat per value; tdata carries the operand, tuser the
//   format (0 unsigned decimal, 1 signed decimal, 2 octal, 3 hex with 0x).
//   master channel: one beat per character, most significant first, tlast on
//   the final character; leading zeros are dropped, zero prints as one 0.
// operation
//   decimal values first pass a bit-serial bcd converter.
//   the emitter then walks its digit slots one per cycle (11 at 32 bits, 22 at
//   64), dropping leading zero slots and sending any prefix and then the rest
//   as characters; a stalled receiver holds it before each character.
//   octal and hex skip the converter. one value is in flight at a time:
//   o_s_tready rises once the emitter state has returned to idle after the
//   last character and the sequencer state has followed it back to idle.
// reset and stall
//   reset drops all control state and any pending text. a stalled receiver
//   holds the current beat in the output register and halts the emitter.
// ----------------------------------------------------------------------------
module integer_to_ascii_formatter_unit #(
    parameter int VALUE_BITS = icf_pkg::ICF_VALUE_BITS
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // slave side
    input  logic                               i_s_tvalid,
    output logic                               o_s_tready,
    input  logic [((VALUE_BITS+7)/8)*8-1:0]    i_s_tdata,   // value
    input  logic [1:0]                         i_s_tuser,   // op
    // master side
    output logic                               o_m_tvalid,
    input  logic                               i_m_tready,
    output logic [7:0]                         o_m_tdata,   // char_code
    output logic                               o_m_tlast    // last
);
    import icf_pkg::*;

    localparam int DEC_DIGITS = (VALUE_BITS * 30103) / 100000 + 1;
    localparam int OCT_DIGITS = (VALUE_BITS + 2) / 3;
    localparam int HEX_DIGITS = (VALUE_BITS + 3) / 4;
    localparam int NDIG_A     = (DEC_DIGITS > HEX_DIGITS) ? DEC_DIGITS : HEX_DIGITS;
    localparam int NDIG       = (NDIG_A > OCT_DIGITS) ? NDIG_A : OCT_DIGITS;

    t_top_state               r_state, n_state;
    t_prefix                  r_prefix;

    logic                     accept;
    logic [VALUE_BITS-1:0]    value;
    logic                     neg;
    logic [VALUE_BITS-1:0]    mag;
    logic                     conv_done;
    logic [4*DEC_DIGITS-1:0]  bcd;
    logic                     emit_idle;
    t_emit_cmd                cmd;
    logic [4*NDIG-1:0]        digits;
    logic [4*NDIG-1:0]        oct_dig;
    logic [4*NDIG-1:0]        hex_dig;
    logic [4*NDIG-1:0]        dec_dig;
    logic [3*OCT_DIGITS-1:0]  oct_pad;
    logic [4*HEX_DIGITS-1:0]  hex_pad;

    assign accept = i_s_tvalid && o_s_tready;
    assign value  = i_s_tdata[VALUE_BITS-1:0];
    assign neg    = (i_s_tuser == OP_SDEC) && value[VALUE_BITS-1];
    assign mag    = neg ? (~value + {{(VALUE_BITS-1){1'b0}}, 1'b1}) : value;

    // digit vectors for each radix, most significant slot on top
    assign oct_pad = {{(3*OCT_DIGITS-VALUE_BITS){1'b0}}, value};
    assign hex_pad = {{(4*HEX_DIGITS-VALUE_BITS){1'b0}}, value};
    assign dec_dig = {{(4*(NDIG-DEC_DIGITS)){1'b0}}, bcd};
    always_comb begin
        oct_dig = '0;
        hex_dig = '0;
        for (int i = 0; i < OCT_DIGITS; i++) begin
            oct_dig[4*i +: 4] = {1'b0, oct_pad[3*i +: 3]};
        end
        for (int i = 0; i < HEX_DIGITS; i++) begin
            hex_dig[4*i +: 4] = hex_pad[4*i +: 4];
        end
    end

    // sequencer: accept, convert, emit
    always_comb begin
        n_state    = r_state;
        cmd.load   = 1'b0;
        cmd.prefix = PFX_NONE;
        digits     = dec_dig;
        unique case (r_state)
            T_IDLE: begin
                if (accept) begin
                    if (i_s_tuser == OP_OCT) begin
                        cmd.load = 1'b1;
                        digits   = oct_dig;
                        n_state  = T_EMIT;
                    end else if (i_s_tuser == OP_HEX) begin
                        cmd.load   = 1'b1;
                        cmd.prefix = PFX_HEX;
                        digits     = hex_dig;
                        n_state    = T_EMIT;
                    end else begin
                        n_state = T_CONV;
                    end
                end
            end
            T_CONV: begin
                if (conv_done) begin
                    cmd.load   = 1'b1;
                    cmd.prefix = r_prefix;
                    n_state    = T_EMIT;
                end
            end
            T_EMIT: begin
                if (emit_idle) begin
                    n_state = T_IDLE;
                end
            end
            default: n_state = T_IDLE;
        endcase
    end

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= T_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // sign prefix for the decimal path
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_prefix <= neg ? PFX_MINUS : PFX_NONE;
        end
    end

    assign o_s_tready = (r_state == T_IDLE);

    // bit-serial decimal converter
    icf_dabble #(
        .VALUE_BITS (VALUE_BITS),
        .DEC_DIGITS (DEC_DIGITS)
    ) u_dabble (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (accept && (i_s_tuser == OP_UDEC || i_s_tuser == OP_SDEC)),
        .i_value (mag),
        .o_done  (conv_done),
        .o_bcd   (bcd)
    );

    // character emitter with output register
    icf_emit #(
        .NDIG (NDIG)
    ) u_emit (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (cmd),
        .i_digits   (digits),
        .o_idle     (emit_idle),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tlast  (o_m_tlast)
    );

endmodule
